// ===== hdl/gn3d_pkg.sv =====
`timescale 1ns / 1ps

package gn3d_pkg;

	// Default fixed-point formats.
	localparam int COORD_FRAC_BITS_DEF = 16;
	localparam int OUT_FRAC_BITS_DEF   = 14;

	// Permutation table geometry.
	localparam int PERM_DEPTH = 256;
	localparam int PERM_AW    = 8;
	localparam int PERM_DW    = 8;

	// Command codes carried in tuser.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	// Gradient selection codes.
	localparam logic [3:0] GRAD_P_Y  = 4'd8;
	localparam logic [3:0] GRAD_Q_Y  = 4'd4;
	localparam logic [3:0] GRAD_Q_XA = 4'd12;
	localparam logic [3:0] GRAD_Q_XB = 4'd14;

	// Fade polynomial coefficients 6t^5 - 15t^4 + 10t^3.
	localparam int FADE_C5 = 6;
	localparam int FADE_C4 = 15;
	localparam int FADE_C3 = 10;

	// Saturation bounds of the result.
	localparam int OUT_MAX = 32767;
	localparam int OUT_MIN = -32768;

endpackage

// ===== hdl/gn3d_ram.sv =====
`timescale 1ns / 1ps

module gn3d_ram #(
	parameter int WIDTH = gn3d_pkg::PERM_DW,
	parameter int DEPTH = gn3d_pkg::PERM_DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port; read returns old data on a collision.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/gradient_noise_3d_core.sv =====
`timescale 1ns / 1ps

// Improved 3-D gradient noise core. Every cycle it takes one item: a load item writes one byte of
// the 256-entry permutation table, an evaluate item computes noise at a signed fixed-point point
// and returns one saturated result; a load item returns nothing. Items stream at one per cycle.
// The cell lookup is read at the accept edge; then the hash lookup, the corner lookup, the
// corner gradients and the x, y and z blends are each registered in turn, the z blend writing
// the rescaled and saturated result into the output register. Each lookup is a registered
// read from its own copy of the table; fourteen copies serve the fourteen lookups of one point.
// A load item travels down the same pipeline and updates each copy at the stage that reads it,
// so loads and evaluates take effect strictly in item order. The whole pipeline holds while a
// result waits in the output register and is not taken. The table has no reset; read only
// entries that have been loaded.
module gradient_noise_3d_core #(
	parameter int COORD_FRAC_BITS = gn3d_pkg::COORD_FRAC_BITS_DEF,
	parameter int OUT_FRAC_BITS   = gn3d_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// Fields from bit 0: perm_index[7:0], perm_value[15:8], coord_x[47:16],
	// coord_y[79:48], coord_z[111:80].
	input  logic [111:0] s_tdata,
	// Fields from bit 0: command.
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// Fields from bit 0: noise_value[15:0].
	output logic [15:0]  m_tdata
);

	localparam int F   = COORD_FRAC_BITS;
	localparam int FW  = F + 5;
	localparam int GW  = F + 3;
	localparam int BW  = F + 4;
	localparam int SHL = (OUT_FRAC_BITS >= F) ? (OUT_FRAC_BITS - F) : 0;
	localparam int SHR = (F > OUT_FRAC_BITS) ? (F - OUT_FRAC_BITS) : 0;
	localparam int RW  = BW + SHL + 17;
	localparam int AW  = gn3d_pkg::PERM_AW;
	localparam int DW  = gn3d_pkg::PERM_DW;

	function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
		input logic signed [GW-1:0] gx, input logic signed [GW-1:0] gy,
		input logic signed [GW-1:0] gz);
		logic signed [GW-1:0] p;
		logic signed [GW-1:0] q;
		p = (h < gn3d_pkg::GRAD_P_Y) ? gx : gy;
		if (h < gn3d_pkg::GRAD_Q_Y) begin
			q = gy;
		end else if (h == gn3d_pkg::GRAD_Q_XA || h == gn3d_pkg::GRAD_Q_XB) begin
			q = gx;
		end else begin
			q = gz;
		end
		return (h[0] ? -p : p) + (h[1] ? -q : q);
	endfunction

	function automatic logic signed [BW-1:0] lerp(input logic signed [FW-1:0] t,
		input logic signed [BW-1:0] a, input logic signed [BW-1:0] b);
		logic signed [BW:0]      diff;
		logic signed [FW+BW:0]   prod;
		diff = $signed({b[BW-1], b}) - $signed({a[BW-1], a});
		prod = t * diff;
		return BW'((prod >>> F) + (FW+BW+1)'(a));
	endfunction

	logic en;
	logic accept;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign accept   = s_tvalid && s_tready;

	// Input field split.
	logic [AW-1:0]  in_idx;
	logic [DW-1:0]  in_val;
	logic [31:0]    in_c [3];
	assign in_idx  = s_tdata[7:0];
	assign in_val  = s_tdata[15:8];
	assign in_c[0] = s_tdata[47:16];
	assign in_c[1] = s_tdata[79:48];
	assign in_c[2] = s_tdata[111:80];

	// Pipeline control.
	logic valid_s1, cmd_s1, valid_s2, cmd_s2;
	logic ev_s3, ev_s4, ev_s5, ev_s6;

	// Payload registers.
	logic [AW-1:0]         idx_s1, idx_s2;
	logic [DW-1:0]         val_s1, val_s2;
	logic [7:0]            iy_s1, iz_s1, iz_s2;
	logic [F-1:0]          fr_s1 [3];
	logic [F-1:0]          fr_s2 [3];
	logic [F-1:0]          fr_s3 [3];
	logic [F-1:0]          t2_s1 [3];
	logic signed [FW-1:0]  tin_s1 [3];
	logic [F-1:0]          t3_s2 [3];
	logic signed [FW-1:0]  poly_s2 [3];
	logic signed [FW-1:0]  fade_s3 [3];
	logic signed [FW-1:0]  fade_s4 [3];
	logic signed [FW-1:0]  v_s5, w_s5, w_s6;
	logic signed [GW-1:0]  n_s4 [8];
	logic signed [BW-1:0]  lx_s5 [4];
	logic signed [BW-1:0]  ly_s6 [2];
	logic [15:0]           data_q;
	logic                  out_valid_q;

	// Table copies: two for the cell lookup, four for the hash, eight for the corners.
	logic [AW-1:0] ra1 [2];
	logic [DW-1:0] rd1 [2];
	logic [AW-1:0] ra2 [4];
	logic [DW-1:0] rd2 [4];
	logic [AW-1:0] ra3 [8];
	logic [DW-1:0] rd3 [8];
	logic          we1, we2, we3;

	assign we1 = accept && (s_tuser == gn3d_pkg::CMD_LOAD);
	assign we2 = en && valid_s1 && (cmd_s1 == gn3d_pkg::CMD_LOAD);
	assign we3 = en && valid_s2 && (cmd_s2 == gn3d_pkg::CMD_LOAD);

	assign ra1[0] = in_c[0][F+7:F];
	assign ra1[1] = in_c[0][F+7:F] + 8'd1;

	// Hash lookup addresses from the cell lookup.
	logic [7:0] a_h, b_h;
	assign a_h    = rd1[0] + iy_s1;
	assign b_h    = rd1[1] + iy_s1;
	assign ra2[0] = a_h;
	assign ra2[1] = a_h + 8'd1;
	assign ra2[2] = b_h;
	assign ra2[3] = b_h + 8'd1;

	// Corner addresses, corner index bit 0 = x, bit 1 = y, bit 2 = z.
	logic [7:0] aa, ab, ba, bb;
	assign aa = rd2[0] + iz_s2;
	assign ab = rd2[1] + iz_s2;
	assign ba = rd2[2] + iz_s2;
	assign bb = rd2[3] + iz_s2;
	assign ra3[0] = aa;
	assign ra3[1] = ba;
	assign ra3[2] = ab;
	assign ra3[3] = bb;
	assign ra3[4] = aa + 8'd1;
	assign ra3[5] = ba + 8'd1;
	assign ra3[6] = ab + 8'd1;
	assign ra3[7] = bb + 8'd1;

	for (genvar i = 0; i < 2; i++) begin : g_l1
		gn3d_ram #(.WIDTH(DW), .DEPTH(gn3d_pkg::PERM_DEPTH)) u_ram (
			.clk(clk), .we(we1), .waddr(in_idx), .wdata(in_val),
			.re(en), .raddr(ra1[i]), .rdata(rd1[i])
		);
	end
	for (genvar i = 0; i < 4; i++) begin : g_l2
		gn3d_ram #(.WIDTH(DW), .DEPTH(gn3d_pkg::PERM_DEPTH)) u_ram (
			.clk(clk), .we(we2), .waddr(idx_s1), .wdata(val_s1),
			.re(en), .raddr(ra2[i]), .rdata(rd2[i])
		);
	end
	for (genvar i = 0; i < 8; i++) begin : g_l3
		gn3d_ram #(.WIDTH(DW), .DEPTH(gn3d_pkg::PERM_DEPTH)) u_ram (
			.clk(clk), .we(we3), .waddr(idx_s2), .wdata(val_s2),
			.re(en), .raddr(ra3[i]), .rdata(rd3[i])
		);
	end

	// Fade stage one: t*t and t*(6t - 15).
	logic [F-1:0]          fr_in [3];
	logic [F-1:0]          t2_c [3];
	logic signed [FW-1:0]  tin_c [3];
	logic [F-1:0]          t3_c [3];
	logic signed [FW-1:0]  poly_c [3];
	logic signed [FW-1:0]  fade_c [3];
	for (genvar k = 0; k < 3; k++) begin : g_fade
		logic [2*F-1:0]         tt;
		logic [2*F-1:0]         ttt;
		logic signed [FW-1:0]   tx;
		logic signed [FW-1:0]   inner;
		logic signed [2*FW-1:0] pin;
		logic signed [2*FW-1:0] pfd;
		assign fr_in[k] = in_c[k][F-1:0];
		assign tt       = fr_in[k] * fr_in[k];
		assign t2_c[k]  = tt[2*F-1:F];
		assign tx       = $signed({5'b0, fr_in[k]});
		assign inner    = FW'(tx * FW'(gn3d_pkg::FADE_C5))
			- (FW'(gn3d_pkg::FADE_C4) <<< F);
		assign pin      = tx * inner;
		assign tin_c[k] = FW'(pin >>> F);
		assign ttt      = t2_s1[k] * fr_s1[k];
		assign t3_c[k]  = ttt[2*F-1:F];
		assign poly_c[k] = (FW'(gn3d_pkg::FADE_C3) <<< F) + tin_s1[k];
		assign pfd       = $signed({5'b0, t3_s2[k]}) * poly_s2[k];
		assign fade_c[k] = FW'(pfd >>> F);
	end

	// Corner gradients from the low hash bits.
	logic signed [GW-1:0] gx0, gy0, gz0, gx1, gy1, gz1;
	logic signed [GW-1:0] n_c [8];
	assign gx0 = $signed({3'b0, fr_s3[0]});
	assign gy0 = $signed({3'b0, fr_s3[1]});
	assign gz0 = $signed({3'b0, fr_s3[2]});
	assign gx1 = gx0 - (GW'(1) <<< F);
	assign gy1 = gy0 - (GW'(1) <<< F);
	assign gz1 = gz0 - (GW'(1) <<< F);
	for (genvar c = 0; c < 8; c++) begin : g_grad
		assign n_c[c] = grad(rd3[c][3:0], ((c & 1) != 0) ? gx1 : gx0,
			((c & 2) != 0) ? gy1 : gy0, ((c & 4) != 0) ? gz1 : gz0);
	end

	// Final blend, rescale and saturation.
	logic signed [BW-1:0] r_c;
	logic signed [RW-1:0] r_w;
	logic [15:0]          sat_c;
	assign r_c = lerp(w_s6, ly_s6[0], ly_s6[1]);
	assign r_w = ((RW'(r_c)) <<< SHL) >>> SHR;
	always_comb begin
		if (r_w > RW'(gn3d_pkg::OUT_MAX)) begin
			sat_c = 16'(gn3d_pkg::OUT_MAX);
		end else if (r_w < RW'(gn3d_pkg::OUT_MIN)) begin
			sat_c = 16'(gn3d_pkg::OUT_MIN);
		end else begin
			sat_c = r_w[15:0];
		end
	end

	// Control pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			cmd_s1      <= gn3d_pkg::CMD_LOAD;
			valid_s2    <= 1'b0;
			cmd_s2      <= gn3d_pkg::CMD_LOAD;
			ev_s3       <= 1'b0;
			ev_s4       <= 1'b0;
			ev_s5       <= 1'b0;
			ev_s6       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= accept;
			cmd_s1      <= s_tuser;
			valid_s2    <= valid_s1;
			cmd_s2      <= cmd_s1;
			ev_s3       <= valid_s2 && (cmd_s2 == gn3d_pkg::CMD_EVAL);
			ev_s4       <= ev_s3;
			ev_s5       <= ev_s4;
			ev_s6       <= ev_s5;
			out_valid_q <= ev_s6;
		end
	end

	// Data pipeline.
	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1 <= in_idx;
			val_s1 <= in_val;
			iy_s1  <= in_c[1][F+7:F];
			iz_s1  <= in_c[2][F+7:F];
			idx_s2 <= idx_s1;
			val_s2 <= val_s1;
			iz_s2  <= iz_s1;
			for (int k = 0; k < 3; k++) begin
				fr_s1[k]   <= fr_in[k];
				t2_s1[k]   <= t2_c[k];
				tin_s1[k]  <= tin_c[k];
				fr_s2[k]   <= fr_s1[k];
				t3_s2[k]   <= t3_c[k];
				poly_s2[k] <= poly_c[k];
				fr_s3[k]   <= fr_s2[k];
				fade_s3[k] <= fade_c[k];
				fade_s4[k] <= fade_s3[k];
			end
			for (int c = 0; c < 8; c++) begin
				n_s4[c] <= n_c[c];
			end
			for (int j = 0; j < 4; j++) begin
				lx_s5[j] <= lerp(fade_s4[0], BW'(n_s4[2*j]), BW'(n_s4[2*j+1]));
			end
			v_s5     <= fade_s4[1];
			w_s5     <= fade_s4[2];
			ly_s6[0] <= lerp(v_s5, lx_s5[0], lx_s5[1]);
			ly_s6[1] <= lerp(v_s5, lx_s5[2], lx_s5[3]);
			w_s6     <= w_s5;
			data_q   <= sat_c;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = data_q;

`ifndef SYNTHESIS
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");
	a_hold_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> ($stable(ev_s6) && $stable(ev_s5)))
		else $error("pipeline moved during output stall");
	a_load_track: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == gn3d_pkg::CMD_LOAD) |=> (valid_s1 && cmd_s1 == gn3d_pkg::CMD_LOAD))
		else $error("load item lost on entry");
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(en && valid_s2 && cmd_s2 == gn3d_pkg::CMD_LOAD) |=> !ev_s3)
		else $error("load item produced a result");
`endif

endmodule

// ===== tb/tb_gradient_noise_3d_core.sv =====
`timescale 1ns / 1ps

module tb_gradient_noise_3d_core;

	localparam int CFB = gn3d_pkg::COORD_FRAC_BITS_DEF;
	localparam int OFB = gn3d_pkg::OUT_FRAC_BITS_DEF;
	localparam longint ONE = 64'sd1 <<< CFB;

	typedef struct packed {
		logic         command;
		logic [7:0]   perm_index;
		logic [7:0]   perm_value;
		logic [31:0]  coord_x;
		logic [31:0]  coord_y;
		logic [31:0]  coord_z;
	} noise_item_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [111:0] s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [15:0]  m_tdata;

	gradient_noise_3d_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	noise_item_t pending_items[$];
	logic [15:0] expected_noise[$];
	logic [7:0]  perm_shadow[256];
	int          fail_count = 0;
	int          evals_sent = 0;
	int          loads_sent = 0;
	int          results_seen = 0;
	int          send_gap = 0;
	int          hold_cycles = 0;
	int          recv_gap = 0;
	bit          stimulus_done = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Floor division by 2^s (arithmetic shift rounds toward minus infinity).
	function automatic longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint fade_q(longint t);
		longint inner, poly, t2, t3;
		inner = gn3d_pkg::FADE_C5 * t - gn3d_pkg::FADE_C4 * ONE;
		poly = gn3d_pkg::FADE_C3 * ONE + fshift(t * inner, CFB);
		t2 = fshift(t * t, CFB);
		t3 = fshift(t2 * t, CFB);
		return fshift(t3 * poly, CFB);
	endfunction

	function automatic longint lerp_q(longint t, longint a, longint b);
		return a + fshift(t * (b - a), CFB);
	endfunction

	function automatic longint grad_dot(logic [7:0] hash, longint gx, longint gy, longint gz);
		logic [3:0] h;
		longint p, q;
		h = hash[3:0];
		p = (h < gn3d_pkg::GRAD_P_Y) ? gx : gy;
		q = (h < gn3d_pkg::GRAD_Q_Y) ? gy :
			((h == gn3d_pkg::GRAD_Q_XA || h == gn3d_pkg::GRAD_Q_XB) ? gx : gz);
		return (h[0] ? -p : p) + (h[1] ? -q : q);
	endfunction

	function automatic logic [7:0] pt(int i);
		return perm_shadow[i & 255];
	endfunction

	// Noise at one point, computed against the shadow of the permutation table.
	function automatic logic [15:0] predict_noise(noise_item_t it);
		int ix, iy, iz, a, aa, ab, b, ba, bb;
		longint x, y, z, u, v, w, r;
		longint n000, n100, n010, n110, n001, n101, n011, n111;
		ix = it.coord_x[CFB +: 8];
		iy = it.coord_y[CFB +: 8];
		iz = it.coord_z[CFB +: 8];
		x = it.coord_x & (ONE - 1);
		y = it.coord_y & (ONE - 1);
		z = it.coord_z & (ONE - 1);
		u = fade_q(x);
		v = fade_q(y);
		w = fade_q(z);
		a = pt(ix) + iy;
		aa = pt(a) + iz;
		ab = pt(a + 1) + iz;
		b = pt(ix + 1) + iy;
		ba = pt(b) + iz;
		bb = pt(b + 1) + iz;
		n000 = grad_dot(pt(aa), x, y, z);
		n100 = grad_dot(pt(ba), x - ONE, y, z);
		n010 = grad_dot(pt(ab), x, y - ONE, z);
		n110 = grad_dot(pt(bb), x - ONE, y - ONE, z);
		n001 = grad_dot(pt(aa + 1), x, y, z - ONE);
		n101 = grad_dot(pt(ba + 1), x - ONE, y, z - ONE);
		n011 = grad_dot(pt(ab + 1), x, y - ONE, z - ONE);
		n111 = grad_dot(pt(bb + 1), x - ONE, y - ONE, z - ONE);
		r = lerp_q(w, lerp_q(v, lerp_q(u, n000, n100), lerp_q(u, n010, n110)),
			lerp_q(v, lerp_q(u, n001, n101), lerp_q(u, n011, n111)));
		if (OFB >= CFB) begin
			r = r <<< (OFB - CFB);
		end else begin
			r = r >>> (CFB - OFB);
		end
		if (r > gn3d_pkg::OUT_MAX) r = gn3d_pkg::OUT_MAX;
		if (r < gn3d_pkg::OUT_MIN) r = gn3d_pkg::OUT_MIN;
		return r[15:0];
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		fail_count++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got),
			$signed(want), $realtime);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000 + $urandom_range(0, 3);
			1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
			2: return {($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'h0000, 16'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_load(int idx, int val);
		noise_item_t it;
		it.command = gn3d_pkg::CMD_LOAD;
		it.perm_index = 8'(idx);
		it.perm_value = 8'(val);
		it.coord_x = $urandom;
		it.coord_y = $urandom;
		it.coord_z = $urandom;
		pending_items = {pending_items, it};
	endtask

	task automatic queue_eval(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		noise_item_t it;
		it.command = gn3d_pkg::CMD_EVAL;
		it.perm_index = 8'($urandom);
		it.perm_value = 8'($urandom);
		it.coord_x = x;
		it.coord_y = y;
		it.coord_z = z;
		pending_items = {pending_items, it};
	endtask

	// Sender: offers items from the pending queue with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				noise_item_t it;
				it = pending_items.pop_front();
				if (it.command == gn3d_pkg::CMD_EVAL) begin
					expected_noise = {expected_noise, predict_noise(it)};
					evals_sent++;
				end else begin
					perm_shadow[it.perm_index] = it.perm_value;
					loads_sent++;
				end
			end
			if ((s_tvalid && !s_tready) || (send_gap == 0 && pending_items.size() > 0
					&& !(s_tvalid && s_tready && pending_items.size() == 0))) begin
				if (!(s_tvalid && !s_tready)) begin
					s_tvalid <= (pending_items.size() > 0);
					s_tuser <= pending_items[0].command;
					s_tdata <= {pending_items[0].coord_z, pending_items[0].coord_y,
						pending_items[0].coord_x, pending_items[0].perm_value,
						pending_items[0].perm_index};
					send_gap <= ($urandom_range(0, 3) != 0) ? 0 :
						(($urandom_range(0, 15) == 0) ? $urandom_range(5, 30) :
						$urandom_range(1, 3));
				end
			end else begin
				s_tvalid <= 1'b0;
				if (send_gap > 0) send_gap <= send_gap - 1;
			end
		end
	end

	// Receiver: random stalls, plus long hold-offs requested by the stimulus.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_noise.size() == 0) begin
					report_mismatch("unexpected result", m_tdata, 16'h0);
				end else begin
					logic [15:0] want;
					want = expected_noise.pop_front();
					if (m_tdata !== want) report_mismatch("noise_value", m_tdata, want);
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				m_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 4) == 0) begin
					recv_gap <= ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30) :
						$urandom_range(1, 3);
				end
			end
		end
	end

	// Stimulus: fill the table, directed corners, then random traffic.
	initial begin
		int idx[256];
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// Every entry is loaded before any evaluation reads the table.
		foreach (idx[i]) idx[i] = i;
		idx.shuffle();
		queue_load(0, 8'hFF);
		queue_load(255, 8'h00);
		foreach (idx[i]) queue_load(i, idx[i]);
		queue_eval(32'h0, 32'h0, 32'h0);
		queue_eval(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		queue_eval(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_eval(32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_0000);
		queue_eval(32'h0000_8000, 32'hFFFF_8000, 32'h00FF_4000);
		queue_eval(32'h00FF_FFFF, 32'h0001_0000, 32'hFFFF_FFFF);
		queue_eval(32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678);
		// Loads interleaved with reads of the just-written entries.
		queue_load(8'h00, 8'h80);
		queue_eval(32'h0, 32'h0000_7FFF, 32'h0);
		queue_load(8'h7F, 8'h7F);
		queue_eval(32'h007F_0001, 32'h0001_0000, 32'hFF80_0000);
		// Long hold-off on the receiver while the sender keeps offering.
		wait (pending_items.size() == 0);
		hold_cycles = 60;
		repeat (40) queue_eval(rand_coord(), rand_coord(), rand_coord());
		for (int n = 0; n < 1050; n++) begin
			if ($urandom_range(0, 9) == 0) queue_load($urandom_range(0, 255), $urandom);
			else queue_eval(rand_coord(), rand_coord(), rand_coord());
		end
		wait (pending_items.size() == 0);
		@(posedge clk);
		while (expected_noise.size() != 0 || s_tvalid) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Covered %0d table loads and %0d noise evaluations, %0d results checked.",
			loads_sent, evals_sent, results_seen);
		$display("Included full-range coordinates, negative cells and a long output stall.");
		if (fail_count == 0 && expected_noise.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout");
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
